// ===== src/mbse_pkg.sv =====
// shared constants, types and helpers of the border skirt extruder
`default_nettype none

package mbse_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int INDEX_BITS = 24;
    localparam int IDX_W      = INDEX_BITS;
    localparam int LCNT_W     = 5;
    localparam int LAYER_W    = $clog2(MAX_LAYERS);
    localparam int POS_W      = 32;
    localparam int VEC_W      = 16;
    localparam int FRAC_SH    = 14;
    localparam int MUL_A_W    = POS_W + 2;
    localparam int PROD_W     = MUL_A_W + VEC_W;
    localparam int TERM_W     = PROD_W - FRAC_SH;
    localparam int SUM_W      = TERM_W + 2;
    localparam int TRI_W      = $clog2(MAX_LAYERS * (MAX_LAYERS + 1) / 2 + 1);
    localparam int NCOMP      = 3;
    localparam int COMP_W     = $clog2(NCOMP);
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef enum logic [2:0] {
        REG_LAYER_COUNT  = 3'd0,
        REG_DISPLACEMENT = 3'd1,
        REG_OFFSET       = 3'd2,
        REG_DROP         = 3'd3,
        REG_BASE_COUNT   = 3'd4,
        REG_LOOP_LENGTH  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                     busy;
        logic [LCNT_W-1:0]        layers;
        logic signed [POS_W-1:0]  drop;
        logic [IDX_W-1:0]         base;
        logic [IDX_W-1:0]         loop_len;
        logic signed [POS_W-1:0]  bt_step;
        logic signed [POS_W-1:0]  n_step;
    } t_cfg;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [POS_W-1:0] r;
        hi = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
        lo = {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
        if (x > hi) begin
            r = hi[POS_W-1:0];
        end else if (x < lo) begin
            r = lo[POS_W-1:0];
        end else begin
            r = x[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/mbse_if.sv =====
// item and result channel interfaces of the border skirt extruder
`default_nettype none

interface mbse_item_if;
    logic                                     valid;
    logic                                     ready;
    logic [mbse_pkg::IDX_W-1:0]               vertex_index;
    logic [mbse_pkg::IDX_W-1:0]               next_vertex_index;
    logic signed [mbse_pkg::POS_W-1:0]        pos_x;
    logic signed [mbse_pkg::POS_W-1:0]        pos_y;
    logic signed [mbse_pkg::POS_W-1:0]        pos_z;
    logic signed [mbse_pkg::VEC_W-1:0]        normal_x;
    logic signed [mbse_pkg::VEC_W-1:0]        normal_y;
    logic signed [mbse_pkg::VEC_W-1:0]        normal_z;
    logic signed [mbse_pkg::VEC_W-1:0]        bitangent_x;
    logic signed [mbse_pkg::VEC_W-1:0]        bitangent_y;
    logic signed [mbse_pkg::VEC_W-1:0]        bitangent_z;

    modport source (
        output valid, vertex_index, next_vertex_index, pos_x, pos_y, pos_z,
               normal_x, normal_y, normal_z, bitangent_x, bitangent_y, bitangent_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, next_vertex_index, pos_x, pos_y, pos_z,
               normal_x, normal_y, normal_z, bitangent_x, bitangent_y, bitangent_z,
        output ready
    );
endinterface

interface mbse_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [mbse_pkg::POS_W-1:0]        vertex_x;
    logic signed [mbse_pkg::POS_W-1:0]        vertex_y;
    logic signed [mbse_pkg::POS_W-1:0]        vertex_z;
    logic [mbse_pkg::IDX_W-1:0]               prev_index;
    logic [mbse_pkg::IDX_W-1:0]               new_index;
    logic [mbse_pkg::IDX_W-1:0]               next_new_index;
    logic [mbse_pkg::IDX_W-1:0]               next_prev_index;
    logic                                     last_layer;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, prev_index, new_index,
               next_new_index, next_prev_index, last_layer,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, prev_index, new_index,
               next_new_index, next_prev_index, last_layer,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/mbse_div.sv =====
// iterative signed by unsigned divider, one quotient bit per cycle, truncating
`default_nettype none

module mbse_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mbse_pkg::POS_W-1:0]   i_dividend,
    input  logic [mbse_pkg::TRI_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic signed [mbse_pkg::POS_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(mbse_pkg::POS_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [mbse_pkg::TRI_W-1:0]    r_rem;
    logic [mbse_pkg::TRI_W-1:0]    r_div;
    logic [mbse_pkg::POS_W-1:0]    r_q;
    logic                          r_neg;

    logic [mbse_pkg::TRI_W:0]      w_cand;
    logic [mbse_pkg::TRI_W:0]      w_diff;
    logic                          w_ge;
    logic [mbse_pkg::POS_W-1:0]    w_mag;

    assign w_cand = {r_rem, r_q[mbse_pkg::POS_W-1]};
    assign w_ge   = w_cand >= {1'b0, r_div};
    assign w_diff = w_cand - {1'b0, r_div};
    assign w_mag  = i_dividend[mbse_pkg::POS_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(mbse_pkg::POS_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= w_mag;
            r_neg <= i_dividend[mbse_pkg::POS_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[mbse_pkg::TRI_W-1:0] : w_cand[mbse_pkg::TRI_W-1:0];
            r_q   <= {r_q[mbse_pkg::POS_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(~r_q + 1'b1) : $signed(r_q);

endmodule

`default_nettype wire

// ===== src/mbse_cfg.sv =====
// configuration registers and step setup through the shared divider
`default_nettype none

module mbse_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbse_pkg::ADDR_W-1:0]     paddr,
    input  logic [mbse_pkg::DATA_W-1:0]     pwdata,
    output logic [mbse_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    output mbse_pkg::t_cfg                  o_cfg
);

    typedef enum logic [4:0] {
        CS_IDLE    = 5'b00001,
        CS_START_B = 5'b00010,
        CS_WAIT_B  = 5'b00100,
        CS_START_N = 5'b01000,
        CS_WAIT_N  = 5'b10000
    } t_cfg_state;

    t_cfg_state                         r_state;
    t_cfg_state                         n_state;
    logic [mbse_pkg::LCNT_W-1:0]        r_layer_count;
    logic signed [mbse_pkg::POS_W-1:0]  r_disp;
    logic signed [mbse_pkg::POS_W-1:0]  r_offset;
    logic signed [mbse_pkg::POS_W-1:0]  r_drop;
    logic [mbse_pkg::IDX_W-1:0]         r_base;
    logic [mbse_pkg::IDX_W-1:0]         r_loop_len;
    logic signed [mbse_pkg::POS_W-1:0]  r_bt_step;
    logic signed [mbse_pkg::POS_W-1:0]  r_n_step;

    logic                               w_wr;
    mbse_pkg::t_reg_idx                 w_idx;
    logic [mbse_pkg::LCNT_W-1:0]        w_layers;
    logic [mbse_pkg::IDX_W-1:0]         w_len;
    logic [2*mbse_pkg::LCNT_W-1:0]      w_tri_prod;
    logic [mbse_pkg::TRI_W-1:0]         w_tri;
    logic                               w_div_start;
    logic signed [mbse_pkg::POS_W-1:0]  w_div_num;
    logic [mbse_pkg::TRI_W-1:0]         w_div_den;
    logic                               w_div_done;
    logic signed [mbse_pkg::POS_W-1:0]  w_div_quot;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = mbse_pkg::t_reg_idx'(paddr[mbse_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= mbse_pkg::LCNT_W'(1);
            r_disp        <= '0;
            r_offset      <= '0;
            r_drop        <= '0;
            r_base        <= '0;
            r_loop_len    <= mbse_pkg::IDX_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                mbse_pkg::REG_LAYER_COUNT:  r_layer_count <= pwdata[mbse_pkg::LCNT_W-1:0];
                mbse_pkg::REG_DISPLACEMENT: r_disp        <= pwdata;
                mbse_pkg::REG_OFFSET:       r_offset      <= pwdata;
                mbse_pkg::REG_DROP:         r_drop        <= pwdata;
                mbse_pkg::REG_BASE_COUNT:   r_base        <= pwdata[mbse_pkg::IDX_W-1:0];
                mbse_pkg::REG_LOOP_LENGTH:  r_loop_len    <= pwdata[mbse_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            mbse_pkg::REG_LAYER_COUNT:  prdata = mbse_pkg::DATA_W'(r_layer_count);
            mbse_pkg::REG_DISPLACEMENT: prdata = r_disp;
            mbse_pkg::REG_OFFSET:       prdata = r_offset;
            mbse_pkg::REG_DROP:         prdata = r_drop;
            mbse_pkg::REG_BASE_COUNT:   prdata = mbse_pkg::DATA_W'(r_base);
            mbse_pkg::REG_LOOP_LENGTH:  prdata = mbse_pkg::DATA_W'(r_loop_len);
            default:                    prdata = '0;
        endcase
    end

    // clamped layer count, loop length and triangle number
    always_comb begin
        if (r_layer_count == '0) begin
            w_layers = mbse_pkg::LCNT_W'(1);
        end else if (r_layer_count > mbse_pkg::LCNT_W'(mbse_pkg::MAX_LAYERS)) begin
            w_layers = mbse_pkg::LCNT_W'(mbse_pkg::MAX_LAYERS);
        end else begin
            w_layers = r_layer_count;
        end
    end

    assign w_len      = (r_loop_len == '0) ? mbse_pkg::IDX_W'(1) : r_loop_len;
    assign w_tri_prod = (2*mbse_pkg::LCNT_W)'(w_layers)
                      * ((2*mbse_pkg::LCNT_W)'(w_layers) + (2*mbse_pkg::LCNT_W)'(1));
    assign w_tri      = w_tri_prod[mbse_pkg::TRI_W:1];

    always_comb begin
        n_state = r_state;
        if (w_wr) begin
            n_state = CS_START_B;
        end else begin
            unique case (r_state)
                CS_IDLE:    n_state = CS_IDLE;
                CS_START_B: n_state = CS_WAIT_B;
                CS_WAIT_B:  if (w_div_done) n_state = CS_START_N;
                CS_START_N: n_state = CS_WAIT_N;
                CS_WAIT_N:  if (w_div_done) n_state = CS_IDLE;
                default:    n_state = CS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= CS_IDLE;
            r_bt_step <= '0;
            r_n_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == CS_WAIT_B && w_div_done) begin
                r_bt_step <= w_div_quot;
            end
            if (r_state == CS_WAIT_N && w_div_done) begin
                r_n_step <= w_div_quot;
            end
        end
    end

    assign w_div_start = (r_state == CS_START_B) || (r_state == CS_START_N);
    assign w_div_num   = (r_state == CS_START_B) ? r_disp : r_offset;
    assign w_div_den   = (r_state == CS_START_B) ? mbse_pkg::TRI_W'(w_layers) : w_tri;

    mbse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    assign o_cfg.busy     = (r_state != CS_IDLE) | w_wr;
    assign o_cfg.layers   = w_layers;
    assign o_cfg.drop     = r_drop;
    assign o_cfg.base     = r_base;
    assign o_cfg.loop_len = w_len;
    assign o_cfg.bt_step  = r_bt_step;
    assign o_cfg.n_step   = r_n_step;

endmodule

`default_nettype wire

// ===== src/mbse_core.sv =====
// layer sequencer around one shared multiplier, with the result register
`default_nettype none

module mbse_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbse_pkg::t_cfg  i_cfg,
    mbse_item_if.sink       i_item,
    mbse_result_if.source   o_result
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BT    = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_core_state;

    localparam logic [mbse_pkg::COMP_W-1:0] LAST_COMP = mbse_pkg::COMP_W'(mbse_pkg::NCOMP - 1);

    t_core_state                          r_state;
    t_core_state                          n_state;
    logic [mbse_pkg::COMP_W-1:0]          r_cnt;
    logic [mbse_pkg::LAYER_W-1:0]         r_k;
    logic [mbse_pkg::IDX_W-1:0]           r_border;
    logic                                 r_wb_valid;
    logic                                 r_wb_bt;
    logic [mbse_pkg::COMP_W-1:0]          r_wb_c;
    logic                                 r_out_valid;

    logic signed [mbse_pkg::POS_W-1:0]    r_pos [mbse_pkg::NCOMP];
    logic signed [mbse_pkg::VEC_W-1:0]    r_nv  [mbse_pkg::NCOMP];
    logic signed [mbse_pkg::VEC_W-1:0]    r_bv  [mbse_pkg::NCOMP];
    logic signed [mbse_pkg::TERM_W-1:0]   r_bt  [mbse_pkg::NCOMP];
    logic signed [mbse_pkg::MUL_A_W-1:0]  r_dn;
    logic signed [mbse_pkg::MUL_A_W-1:0]  r_nacc;
    logic signed [mbse_pkg::PROD_W-1:0]   r_prod;
    logic [mbse_pkg::IDX_W-1:0]           r_prev_self;
    logic [mbse_pkg::IDX_W-1:0]           r_prev_next;
    logic [mbse_pkg::IDX_W-1:0]           r_base;
    logic [mbse_pkg::IDX_W-1:0]           r_j;
    logic [mbse_pkg::IDX_W-1:0]           r_jn;
    logic signed [mbse_pkg::POS_W-1:0]    r_out_v [mbse_pkg::NCOMP];
    logic [mbse_pkg::IDX_W-1:0]           r_out_prev;
    logic [mbse_pkg::IDX_W-1:0]           r_out_new;
    logic [mbse_pkg::IDX_W-1:0]           r_out_next_new;
    logic [mbse_pkg::IDX_W-1:0]           r_out_next_prev;
    logic                                 r_out_last;

    logic                                 w_accept;
    logic                                 w_out_free;
    logic                                 w_load;
    logic                                 w_last;
    logic [mbse_pkg::IDX_W-1:0]           w_j;
    logic [mbse_pkg::IDX_W:0]             w_j_inc;
    logic [mbse_pkg::IDX_W-1:0]           w_jn;
    logic [mbse_pkg::IDX_W-1:0]           w_new;
    logic [mbse_pkg::IDX_W-1:0]           w_next_new;
    logic signed [mbse_pkg::MUL_A_W-1:0]  w_ns_ext;
    logic signed [mbse_pkg::MUL_A_W-1:0]  w_drop_ext;
    logic signed [mbse_pkg::MUL_A_W-1:0]  w_nacc_inc;
    logic signed [mbse_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [mbse_pkg::VEC_W-1:0]    w_mul_b;
    logic signed [mbse_pkg::PROD_W-1:0]   w_prod;
    logic signed [mbse_pkg::TERM_W-1:0]   w_term;
    logic signed [mbse_pkg::POS_W-1:0]    w_pos_c;
    logic signed [mbse_pkg::TERM_W-1:0]   w_bt_c;
    logic signed [mbse_pkg::SUM_W-1:0]    w_sum;

    assign w_accept   = i_item.valid & i_item.ready;
    assign w_out_free = !r_out_valid | o_result.ready;
    assign w_load     = (r_state == ST_EMIT) & w_out_free;
    assign w_last     = (mbse_pkg::LCNT_W'(r_k) + mbse_pkg::LCNT_W'(1)) == i_cfg.layers;

    assign i_item.ready = (r_state == ST_IDLE) & !i_cfg.busy;

    // border position, restarted when the loop was shortened
    assign w_j     = (r_border >= i_cfg.loop_len) ? '0 : r_border;
    assign w_j_inc = {1'b0, w_j} + (mbse_pkg::IDX_W+1)'(1);
    assign w_jn    = (w_j_inc >= {1'b0, i_cfg.loop_len}) ? '0 : w_j_inc[mbse_pkg::IDX_W-1:0];

    assign w_new      = r_base + r_j;
    assign w_next_new = r_base + r_jn;

    assign w_ns_ext   = {{(mbse_pkg::MUL_A_W-mbse_pkg::POS_W){i_cfg.n_step[mbse_pkg::POS_W-1]}},
                         i_cfg.n_step};
    assign w_drop_ext = {{(mbse_pkg::MUL_A_W-mbse_pkg::POS_W){i_cfg.drop[mbse_pkg::POS_W-1]}},
                         i_cfg.drop};
    assign w_nacc_inc = r_nacc + w_ns_ext;

    // shared multiplier operands
    always_comb begin
        if (r_state == ST_BT) begin
            w_mul_a = {{(mbse_pkg::MUL_A_W-mbse_pkg::POS_W){i_cfg.bt_step[mbse_pkg::POS_W-1]}},
                       i_cfg.bt_step};
            w_mul_b = r_bv[r_cnt];
        end else begin
            w_mul_a = r_dn;
            w_mul_b = r_nv[r_cnt];
        end
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_term  = r_prod[mbse_pkg::PROD_W-1:mbse_pkg::FRAC_SH];
    assign w_pos_c = r_pos[r_wb_c];
    assign w_bt_c  = r_bt[r_wb_c];
    assign w_sum   = {{(mbse_pkg::SUM_W-mbse_pkg::POS_W){w_pos_c[mbse_pkg::POS_W-1]}}, w_pos_c}
                   + {{(mbse_pkg::SUM_W-mbse_pkg::TERM_W){w_bt_c[mbse_pkg::TERM_W-1]}}, w_bt_c}
                   + {{(mbse_pkg::SUM_W-mbse_pkg::TERM_W){w_term[mbse_pkg::TERM_W-1]}}, w_term};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_BT;
            ST_BT:    if (r_cnt == LAST_COMP) n_state = ST_MUL;
            ST_MUL:   if (r_cnt == LAST_COMP) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_EMIT;
            ST_EMIT:  if (w_load) n_state = w_last ? ST_IDLE : ST_MUL;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_border    <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wb_valid <= (r_state == ST_BT) || (r_state == ST_MUL);
            if ((r_state == ST_BT) || (r_state == ST_MUL)) begin
                r_cnt <= (r_cnt == LAST_COMP) ? '0 : r_cnt + 1'b1;
            end
            if (w_accept) begin
                r_k      <= '0;
                r_border <= w_jn;
            end else if (w_load && !w_last) begin
                r_k <= r_k + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_wb_bt <= (r_state == ST_BT);
        r_wb_c  <= r_cnt;
        if (w_accept) begin
            r_pos[0]    <= i_item.pos_x;
            r_pos[1]    <= i_item.pos_y;
            r_pos[2]    <= i_item.pos_z;
            r_nv[0]     <= i_item.normal_x;
            r_nv[1]     <= i_item.normal_y;
            r_nv[2]     <= i_item.normal_z;
            r_bv[0]     <= i_item.bitangent_x;
            r_bv[1]     <= i_item.bitangent_y;
            r_bv[2]     <= i_item.bitangent_z;
            r_prev_self <= i_item.vertex_index;
            r_prev_next <= i_item.next_vertex_index;
            r_base      <= i_cfg.base;
            r_j         <= w_j;
            r_jn        <= w_jn;
            r_nacc      <= w_ns_ext;
            r_dn        <= w_ns_ext + w_drop_ext;
        end
        if (r_wb_valid) begin
            if (r_wb_bt) begin
                r_bt[r_wb_c] <= w_term;
            end else begin
                r_pos[r_wb_c] <= mbse_pkg::sat_pos(w_sum);
            end
        end
        if (w_load) begin
            r_out_v[0]      <= r_pos[0];
            r_out_v[1]      <= r_pos[1];
            r_out_v[2]      <= r_pos[2];
            r_out_prev      <= r_prev_self;
            r_out_new       <= w_new;
            r_out_next_new  <= w_next_new;
            r_out_next_prev <= r_prev_next;
            r_out_last      <= w_last;
            r_prev_self     <= w_new;
            r_prev_next     <= w_next_new;
            if (!w_last) begin
                r_base <= r_base + i_cfg.loop_len;
                r_nacc <= w_nacc_inc;
                r_dn   <= w_nacc_inc;
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.vertex_x        = r_out_v[0];
    assign o_result.vertex_y        = r_out_v[1];
    assign o_result.vertex_z        = r_out_v[2];
    assign o_result.prev_index      = r_out_prev;
    assign o_result.new_index       = r_out_new;
    assign o_result.next_new_index  = r_out_next_new;
    assign o_result.next_prev_index = r_out_next_prev;
    assign o_result.last_layer      = r_out_last;

`ifndef SYNTHESIS
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.busy |-> !i_item.ready)
        else $error("item taken while steps are being set up");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_BT) && (r_k == '0))
        else $error("accepted item did not start at layer zero");

    a_wb_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> $past((r_state == ST_BT) || (r_state == ST_MUL)))
        else $error("writeback without a product issued");

    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !r_wb_valid)
        else $error("result loaded while a writeback is pending");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == ST_IDLE) && r_out_valid && r_out_last)
        else $error("final layer did not close the item");
`endif

endmodule

`default_nettype wire

// ===== src/mesh_border_skirt_extruder_unit.sv =====
// top level of the mesh border skirt extruder
//
// i_item carries one border vertex per item (valid/ready); o_result gives one
// new skirt vertex and its triangle corner indices per layer, L results per
// item, the last one flagged by last_layer. Registers are written over the
// APB-style port, pready is always high.
// The next item is taken only after the last layer of an item is loaded:
// a single shared multiplier forms the three bitangent terms once per item
// and three normal terms per layer, each layer then passes a drain state
// and a load of the result register. The first result passes the bitangent,
// multiply, drain and emit states and can wait in emit for the result register.
// Every register write restarts the step setup in the one-bit-per-cycle
// divider, and i_item.ready stays low until both steps are set.
// Reset is synchronous: registers take their reset values, steps and the
// border position are zero, no item is in flight and o_result.valid is low.
// When the receiver holds o_result.ready low, the result register keeps its
// item and the sequencer waits before loading the next layer.

`default_nettype none

module mesh_border_skirt_extruder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mbse_item_if.sink                       i_item,
    mbse_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbse_pkg::ADDR_W-1:0]     paddr,
    input  logic [mbse_pkg::DATA_W-1:0]     pwdata,
    output logic [mbse_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    mbse_pkg::t_cfg w_cfg;

    mbse_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mbse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
